### design/rgbkc_pkg.sv
// rgbkc_pkg: shared types, constants and register codes of the rgb kernel convolution core
// no dependencies; imported by every module of the block except rgbkc_fifo

package rgbkc_pkg;

  localparam int unsigned KERNEL_SIZE_DEF    = 3;
  localparam int unsigned MAX_WIDTH_DEF      = 2048;
  localparam int unsigned COEF_FRAC_BITS_DEF = 8;

  localparam int unsigned KMAX         = 5;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned PIX_W        = 3 * CH_W;
  localparam int unsigned COEF_W       = 12;
  localparam int unsigned ROW_CFG_W    = KMAX * COEF_W;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned WIDTH_CFG_W  = 12;
  localparam int unsigned HEIGHT_CFG_W = 16;
  localparam int unsigned ROW_W        = HEIGHT_CFG_W + 1;
  localparam int unsigned PROD_W       = COEF_W + CH_W + 1;
  localparam int unsigned HSEL_W       = 3;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_ROW0  = 3'd2,
    REG_KERNEL_ROW1  = 3'd3,
    REG_KERNEL_ROW2  = 3'd4,
    REG_KERNEL_ROW3  = 3'd5,
    REG_KERNEL_ROW4  = 3'd6
  } cfg_reg_e;

  typedef logic [KMAX-1:0][ROW_CFG_W-1:0] kernel_rows_t;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 16'd480;
  localparam kernel_rows_t KERNEL_RST = {60'h0, 60'h0, 60'h0, 60'h100000, 60'h0};

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_last;
  } out_item_t;

  typedef struct packed {
    logic                        emit;
    logic                        last;
    logic [KMAX-1:0][HSEL_W-1:0] hsel;
  } front_ctl_t;

endpackage

### design/rgbkc_front.sv
// rgbkc_front: position tracking, line memories and column read of the convolution core
// depends on rgbkc_pkg

module rgbkc_front import rgbkc_pkg::*; #(
  parameter int unsigned KERNEL_SIZE = KERNEL_SIZE_DEF,
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  in_item_t                             item_i,
  input  logic [WIDTH_CFG_W-1:0]               image_width_i,
  input  logic [HEIGHT_CFG_W-1:0]              image_height_i,
  input  logic [FIFO_CNT_W-1:0]                fifo_count_i,
  output logic                                 entry_valid_o,
  output front_ctl_t                           entry_ctl_o,
  output logic [KERNEL_SIZE-1:0][PIX_W-1:0]    entry_col_o
);

  localparam int          HALF_K = (KERNEL_SIZE - 1) / 2;
  localparam int unsigned SLOTS  = 2 * KERNEL_SIZE;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LW_W   = $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0]  ic_q, ic_d, ox_q, ox_d;
  logic [ROW_W-1:0]  ir_q, ir_d, oy_q, oy_d;
  logic [SLOT_W-1:0] ws_q, ws_d;

  logic                    acc, wr, col_end, emit, last;
  logic [LW_W-1:0]         line_w;
  logic [HEIGHT_CFG_W-1:0] frame_h;
  logic [PIX_W-1:0]        pix;
  front_ctl_t              ctl;
  logic [KERNEL_SIZE-1:0][SLOT_W-1:0] slot_sel;

  logic                               st_v_q;
  front_ctl_t                         st_ctl_q;
  logic [KERNEL_SIZE-1:0][SLOT_W-1:0] st_sel_q;
  logic [PIX_W-1:0]                   st_pix_q;
  logic [SLOT_W-1:0]                  st_ws_q;
  logic                               st_wr_q;
  logic [PIX_W-1:0]                   rd_q [SLOTS];

  assign full_o = (int'(fifo_count_i) + int'(st_v_q)) >= FIFO_DEPTH;
  assign acc    = push_i && !full_o;
  assign pix    = {item_i.pixel_blue, item_i.pixel_green, item_i.pixel_red};

  always_comb begin
    if (image_width_i == '0) begin
      line_w = LW_W'(1);
    end else if (int'(image_width_i) > int'(MAX_WIDTH)) begin
      line_w = LW_W'(MAX_WIDTH);
    end else begin
      line_w = LW_W'(image_width_i);
    end
    frame_h = (image_height_i == '0) ? HEIGHT_CFG_W'(1) : image_height_i;
  end

  // classification of the item at the current positions
  always_comb begin
    int row_back, deff, sidx, cpos;
    wr      = !item_i.func && (int'(ir_q) < int'(frame_h)) && (int'(ic_q) < int'(line_w));
    col_end = (int'(ic_q) + 1) >= int'(line_w);
    emit    = (int'(ir_q) > HALF_K) || (int'(ir_q) == HALF_K && int'(ic_q) >= HALF_K);
    last    = emit && ((int'(oy_q) >= int'(frame_h)) ||
              ((int'(oy_q) + 1 == int'(frame_h)) && (int'(ox_q) + 1 >= int'(line_w))));
    for (int t = 0; t < KERNEL_SIZE; t++) begin
      row_back = 2 * HALF_K - t;
      if (int'(ir_q) < row_back) begin
        deff = int'(ir_q);
      end else if (int'(ir_q) - row_back >= int'(frame_h)) begin
        deff = int'(ir_q) - int'(frame_h) + 1;
      end else begin
        deff = row_back;
      end
      if (deff > 2 * HALF_K) begin
        deff = 2 * HALF_K;
      end
      sidx = int'(ws_q) - deff;
      if (sidx < 0) begin
        sidx = sidx + int'(SLOTS);
      end
      slot_sel[t] = SLOT_W'(sidx);
    end
    ctl.emit = emit;
    ctl.last = last;
    for (int k = 0; k < KMAX; k++) begin
      if (k < KERNEL_SIZE) begin
        cpos = int'(ox_q) + k - HALF_K;
        if (cpos < 0) begin
          cpos = 0;
        end else if (cpos >= int'(line_w)) begin
          cpos = int'(line_w) - 1;
        end
        ctl.hsel[k] = HSEL_W'(int'(ox_q) + HALF_K - cpos);
      end else begin
        ctl.hsel[k] = '0;
      end
    end
  end

  always_comb begin
    ic_d = ic_q;
    ir_d = ir_q;
    ws_d = ws_q;
    ox_d = ox_q;
    oy_d = oy_q;
    if (acc) begin
      if (last) begin
        ic_d = '0;
        ir_d = '0;
        ws_d = '0;
        ox_d = '0;
        oy_d = '0;
      end else begin
        if (col_end) begin
          ic_d = '0;
          ir_d = ROW_W'(ir_q + 1'b1);
          ws_d = (ws_q == SLOT_W'(SLOTS - 1)) ? '0 : SLOT_W'(ws_q + 1'b1);
        end else begin
          ic_d = COL_W'(ic_q + 1'b1);
        end
        if (emit) begin
          if ((int'(ox_q) + 1) >= int'(line_w)) begin
            ox_d = '0;
            oy_d = ROW_W'(oy_q + 1'b1);
          end else begin
            ox_d = COL_W'(ox_q + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q   <= '0;
      ir_q   <= '0;
      ws_q   <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
      st_v_q <= 1'b0;
    end else begin
      ic_q   <= ic_d;
      ir_q   <= ir_d;
      ws_q   <= ws_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      st_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      st_ctl_q <= ctl;
      st_sel_q <= slot_sel;
      st_pix_q <= pix;
      st_ws_q  <= ws_q;
      st_wr_q  <= wr;
    end
  end

  // one line memory per slot, read-first
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (acc && wr && ws_q == SLOT_W'(s)) begin
        mem[ic_q] <= pix;
      end
      if (acc) begin
        rd_q[s] <= mem[ic_q];
      end
    end
  end

  // current line bypasses its own memory when written
  always_comb begin
    for (int t = 0; t < KERNEL_SIZE; t++) begin
      entry_col_o[t] = (st_wr_q && st_sel_q[t] == st_ws_q) ? st_pix_q : rd_q[st_sel_q[t]];
    end
  end

  assign entry_valid_o = st_v_q;
  assign entry_ctl_o   = st_ctl_q;

endmodule

### design/rgbkc_fifo.sv
// rgbkc_fifo: short register queue between the front and the back of the convolution core
// depends on nothing beyond its parameters

module rgbkc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_q + 1'b1);
    end
    cnt_d = CNT_W'(cnt_q + CNT_W'(push_i) - CNT_W'(do_pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### design/rgbkc_back.sv
// rgbkc_back: column window, multiply, sum, rounding and result register of the convolution core
// depends on rgbkc_pkg

module rgbkc_back import rgbkc_pkg::*; #(
  parameter int unsigned KERNEL_SIZE    = KERNEL_SIZE_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fifo_empty_i,
  input  front_ctl_t                        fifo_ctl_i,
  input  logic [KERNEL_SIZE-1:0][PIX_W-1:0] fifo_col_i,
  output logic                              fifo_pop_o,
  input  kernel_rows_t                      kernel_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output out_item_t                         item_o
);

  localparam int unsigned WIN      = KERNEL_SIZE - 1;
  localparam int unsigned POS_W    = $clog2(KERNEL_SIZE);
  localparam int unsigned ROWSUM_W = PROD_W + $clog2(KERNEL_SIZE);
  localparam int unsigned SUM_W    = PROD_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (COEF_FRAC_BITS - 1));

  logic adv, take;
  logic [KERNEL_SIZE-1:0][PIX_W-1:0] win_q [WIN];
  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] pos;

  logic signed [PROD_W-1:0]   prod_d [3][KERNEL_SIZE][KERNEL_SIZE];
  logic signed [PROD_W-1:0]   prod_q [3][KERNEL_SIZE][KERNEL_SIZE];
  logic signed [ROWSUM_W-1:0] rsum_d [3][KERNEL_SIZE];
  logic signed [ROWSUM_W-1:0] rsum_q [3][KERNEL_SIZE];
  logic signed [SUM_W-1:0]    sum_d [3];
  logic signed [SUM_W-1:0]    sum_q [3];
  logic [CH_W-1:0]            chan_d [3];
  logic v1_q, v2_q, v3_q, out_v_q;
  logic l1_q, l2_q, l3_q;
  out_item_t item_q;

  assign adv        = !out_v_q || pop_i;
  assign take       = adv && !fifo_empty_i;
  assign fifo_pop_o = take;
  assign empty_o    = !out_v_q;
  assign item_o     = item_q;

  always_comb begin
    pos[0] = fifo_col_i;
    for (int j = 1; j < KERNEL_SIZE; j++) begin
      pos[j] = win_q[j-1];
    end
  end

  always_comb begin
    logic [PIX_W-1:0]         px;
    logic signed [COEF_W-1:0] coef;
    for (int t = 0; t < KERNEL_SIZE; t++) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        px   = pos[fifo_ctl_i.hsel[k][POS_W-1:0]][t];
        coef = $signed(kernel_i[t][k*COEF_W +: COEF_W]);
        for (int c = 0; c < 3; c++) begin
          prod_d[c][t][k] = PROD_W'(coef) * PROD_W'($signed({1'b0, px[c*CH_W +: CH_W]}));
        end
      end
    end
  end

  always_comb begin
    logic signed [ROWSUM_W-1:0] racc;
    logic signed [SUM_W-1:0]    sacc;
    for (int c = 0; c < 3; c++) begin
      for (int t = 0; t < KERNEL_SIZE; t++) begin
        racc = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
          racc = racc + ROWSUM_W'(prod_q[c][t][k]);
        end
        rsum_d[c][t] = racc;
      end
      sacc = '0;
      for (int t = 0; t < KERNEL_SIZE; t++) begin
        sacc = sacc + SUM_W'(rsum_q[c][t]);
      end
      sum_d[c] = sacc;
    end
  end

  // round half away from zero, then saturate to 0..255
  always_comb begin
    logic signed [SUM_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r = (sum_q[c] + ROUND_HALF) >>> COEF_FRAC_BITS;
      if (sum_q[c] < 0) begin
        chan_d[c] = '0;
      end else if (r > SUM_W'(255)) begin
        chan_d[c] = 8'hff;
      end else begin
        chan_d[c] = r[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= take && fifo_ctl_i.emit;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      win_q[0] <= fifo_col_i;
      for (int j = 1; j < WIN; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
    if (adv) begin
      prod_q            <= prod_d;
      l1_q              <= fifo_ctl_i.last;
      rsum_q            <= rsum_d;
      l2_q              <= l1_q;
      sum_q             <= sum_d;
      l3_q              <= l2_q;
      item_q.out_red    <= chan_d[0];
      item_q.out_green  <= chan_d[1];
      item_q.out_blue   <= chan_d[2];
      item_q.frame_last <= l3_q;
    end
  end

endmodule

### design/rgb_kernel_convolution_core.sv
// rgb_kernel_convolution_core: top level of the streaming rgb 2d convolution filter
// depends on rgbkc_pkg, rgbkc_front, rgbkc_fifo and rgbkc_back

// Streaming RGB filter with a square odd kernel (KERNEL_SIZE 3 or 5) and replicated borders.
// Pixels enter in raster order, one request per clock while the output is not stalled, and
// each result is the kernel-weighted sum of its neighbourhood per channel, rounded half away
// from zero and saturated to 0..255. Result k is produced by input request k + R*width + R,
// with R = (KERNEL_SIZE-1)/2, so the host sends that many flush requests after each frame.
// A result travels from the edge that accepts the request completing it through the line
// memory read at that edge, then the front queue, product, row sum, total sum and result
// registers to the output ports. The line store is
// 2*KERNEL_SIZE memories of MAX_WIDTH pixels, one write and one read port each, holding
// nothing defined until written; there is no clearing pass, so the first request after
// reset is taken at once.

module rgb_kernel_convolution_core import rgbkc_pkg::*; #(
  parameter int unsigned KERNEL_SIZE    = KERNEL_SIZE_DEF,
  parameter int unsigned MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ROW_CFG_W-1:0] cfg_data_i
);

  localparam int unsigned FIFO_W = $bits(front_ctl_t) + KERNEL_SIZE * PIX_W;

  logic [WIDTH_CFG_W-1:0]  width_q;
  logic [HEIGHT_CFG_W-1:0] height_q;
  kernel_rows_t            kernel_q;

  logic                              entry_valid, fifo_empty, fifo_pop;
  front_ctl_t                        entry_ctl, head_ctl;
  logic [KERNEL_SIZE-1:0][PIX_W-1:0] entry_col, head_col;
  logic [FIFO_CNT_W-1:0]             fifo_count;
  logic [FIFO_W-1:0]                 fifo_dout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      kernel_q <= KERNEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q     <= cfg_data_i[WIDTH_CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q    <= cfg_data_i[HEIGHT_CFG_W-1:0];
        REG_KERNEL_ROW0:  kernel_q[0] <= cfg_data_i;
        REG_KERNEL_ROW1:  kernel_q[1] <= cfg_data_i;
        REG_KERNEL_ROW2:  kernel_q[2] <= cfg_data_i;
        REG_KERNEL_ROW3:  kernel_q[3] <= cfg_data_i;
        REG_KERNEL_ROW4:  kernel_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rgbkc_front #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .item_i         (in_i),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .fifo_count_i   (fifo_count),
    .entry_valid_o  (entry_valid),
    .entry_ctl_o    (entry_ctl),
    .entry_col_o    (entry_col)
  );

  rgbkc_fifo #(
    .WIDTH (FIFO_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (entry_valid),
    .data_i  ({entry_ctl, entry_col}),
    .pop_i   (fifo_pop),
    .data_o  (fifo_dout),
    .empty_o (fifo_empty),
    .count_o (fifo_count)
  );

  assign head_ctl = fifo_dout[FIFO_W-1 -: $bits(front_ctl_t)];
  assign head_col = fifo_dout[KERNEL_SIZE*PIX_W-1:0];

  rgbkc_back #(
    .KERNEL_SIZE    (KERNEL_SIZE),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_ctl_i   (head_ctl),
    .fifo_col_i   (head_col),
    .fifo_pop_o   (fifo_pop),
    .kernel_i     (kernel_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .item_o       (out_o)
  );

endmodule

### design/rgbkc_checker.sv
// rgbkc_checker: port-level assertions of the rgb kernel convolution core
// depends on rgbkc_pkg; bound to rgb_kernel_convolution_core below

module rgbkc_checker import rgbkc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_o
);

  logic [31:0] pend_q;

  // requests taken minus results taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 32'(push && !full) - 32'(pop && !empty);
    end
  end

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed or vanished");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != '0))
    else $error("result shown without a pending request");

  a_full_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (pend_q != '0))
    else $error("full with nothing in flight");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("not idle after reset");

endmodule

bind rgb_kernel_convolution_core rgbkc_checker u_checker (.*);
